// ----- design/arpct_pkg.sv -----
// shared types, widths and codes of the arp cache with transpose lookup
package arpct_pkg;

  localparam int unsigned TABLE_DEPTH = 8;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_LEARN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 1'b1;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] found_mac;
    logic             send_request;
    logic             send_reply;
    logic [IP_W-1:0]  peer_ip;
    logic [MAC_W-1:0] peer_mac;
  } rsp_t;

endpackage

// ----- design/arpct_if.sv -----
// valid/ready channel interfaces for request, response and configuration
interface arpct_req_if;
  logic                              valid;
  logic                              ready;
  logic [arpct_pkg::CMD_W-1:0]       cmd;
  logic [arpct_pkg::IP_W-1:0]        src_ip;
  logic [arpct_pkg::MAC_W-1:0]       src_mac;
  logic [arpct_pkg::IP_W-1:0]        tgt_ip;

  modport source (output valid, cmd, src_ip, src_mac, tgt_ip, input ready);
  modport sink   (input valid, cmd, src_ip, src_mac, tgt_ip, output ready);
endinterface

interface arpct_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [arpct_pkg::MAC_W-1:0]       found_mac;
  logic                              send_request;
  logic                              send_reply;
  logic [arpct_pkg::IP_W-1:0]        peer_ip;
  logic [arpct_pkg::MAC_W-1:0]       peer_mac;

  modport source (output valid, found, found_mac, send_request, send_reply, peer_ip,
                  peer_mac, input ready);
  modport sink   (input valid, found, found_mac, send_request, send_reply, peer_ip,
                  peer_mac, output ready);
endinterface

interface arpct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [arpct_pkg::CFG_IDX_W-1:0]   index;
  logic [arpct_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/arpct_ram.sv -----
// generic single write, single read ram with registered read data
module arpct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/arpct_ctrl.sv -----
// sequencer that scans the table ram, updates it and registers the response
module arpct_ctrl #(
  parameter int unsigned TableDepth = arpct_pkg::TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  arpct_req_if.sink                           req_i,
  arpct_rsp_if.source                         rsp_o,
  input  logic [arpct_pkg::IP_W-1:0]          my_ip_i,
  output logic                                ram_we_o,
  output logic [$clog2(TableDepth)-1:0]       ram_waddr_o,
  output arpct_pkg::entry_t                   ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(TableDepth)-1:0]       ram_raddr_o,
  input  arpct_pkg::entry_t                   ram_rdata_i
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TableDepth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_SWAP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [arpct_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [arpct_pkg::IP_W-1:0]  sip_q, sip_d;
  logic [arpct_pkg::MAC_W-1:0] smac_q, smac_d;
  logic [arpct_pkg::IP_W-1:0]  tip_q, tip_d;
  arpct_pkg::entry_t           prev_q, prev_d;
  arpct_pkg::entry_t           hit_q, hit_d;
  arpct_pkg::rsp_t             res_q, res_d;
  arpct_pkg::rsp_t             out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic [CntW-1:0] idx_nxt;
  logic            match;

  assign idx_nxt = CntW'(idx_q) + CntW'(1);
  assign match = (cmd_q == arpct_pkg::CMD_LEARN) ? (ram_rdata_i.mac == smac_q)
                                                 : (ram_rdata_i.ip == tip_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    cmd_d       = cmd_q;
    sip_d       = sip_q;
    smac_d      = smac_q;
    tip_d       = tip_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '{ip: sip_q, mac: smac_q};
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d  = req_i.cmd;
          sip_d  = req_i.src_ip;
          smac_d = req_i.src_mac;
          tip_d  = req_i.tgt_ip;
          res_d  = '0;
          state_d = ST_DONE;
          case (req_i.cmd)
            arpct_pkg::CMD_REQUEST: begin
              if (req_i.tgt_ip == my_ip_i) begin
                res_d.send_reply = 1'b1;
                res_d.peer_ip    = req_i.src_ip;
                res_d.peer_mac   = req_i.src_mac;
              end
            end
            arpct_pkg::CMD_LEARN, arpct_pkg::CMD_RESOLVE: begin
              if (fill_q == '0) begin
                // empty table: learn appends at slot zero, resolve misses
                if (req_i.cmd == arpct_pkg::CMD_LEARN) begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = '0;
                  ram_wdata_o = '{ip: req_i.src_ip, mac: req_i.src_mac};
                  fill_d      = CntW'(1);
                end else begin
                  res_d.send_request = 1'b1;
                  res_d.peer_ip      = req_i.tgt_ip;
                end
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                idx_d       = '0;
                state_d     = ST_SCAN;
              end
            end
            default: begin
              // unused command leaves the table alone
            end
          endcase
        end
      end

      ST_SCAN: begin
        prev_d = ram_rdata_i;
        if (match) begin
          if (cmd_q == arpct_pkg::CMD_LEARN) begin
            ram_we_o = 1'b1;
            state_d  = ST_DONE;
          end else begin
            res_d.found     = 1'b1;
            res_d.found_mac = ram_rdata_i.mac;
            if (idx_q == '0) begin
              state_d = ST_DONE;
            end else begin
              // move the previous entry down, hit goes up next cycle
              ram_we_o    = 1'b1;
              ram_wdata_o = prev_q;
              hit_d       = ram_rdata_i;
              state_d     = ST_SWAP;
            end
          end
        end else if (idx_nxt < fill_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_nxt[IdxW-1:0];
          idx_d       = idx_nxt[IdxW-1:0];
        end else begin
          state_d = ST_DONE;
          if (cmd_q == arpct_pkg::CMD_LEARN) begin
            ram_we_o = 1'b1;
            if (fill_q < FullCnt) begin
              ram_waddr_o = fill_q[IdxW-1:0];
              fill_d      = fill_q + CntW'(1);
            end else begin
              ram_waddr_o = LastIdx;
            end
          end else begin
            res_d.send_request = 1'b1;
            res_d.peer_ip      = tip_q;
          end
        end
      end

      ST_SWAP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q - IdxW'(1);
        ram_wdata_o = hit_q;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    sip_q  <= sip_d;
    smac_q <= smac_d;
    tip_q  <= tip_d;
    prev_q <= prev_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_q.found;
  assign rsp_o.found_mac    = out_q.found_mac;
  assign rsp_o.send_request = out_q.send_request;
  assign rsp_o.send_reply   = out_q.send_reply;
  assign rsp_o.peer_ip      = out_q.peer_ip;
  assign rsp_o.peer_mac     = out_q.peer_mac;

endmodule

// ----- design/arp_cache_transpose_core.sv -----
// top level of the arp cache with transpose lookup: config, table ram, sequencer
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    cmd, src_ip, src_mac, tgt_ip
//   rsp_o    out  valid/ready    found, found_mac, send_request, send_reply, peer_ip, peer_mac
//   cfg_i    in   valid/ready    index, data (ready is always high)
//
// a learn or resolve request on a non-empty table scans its entries before the response, plus a
// swap step when a resolve hit swaps an entry; a received arp request goes straight to the response.
// the scan reads one entry per cycle through the single read port of the table ram.
// a new request is taken once the sequencer is idle, while the response register
// still waits for its sink. reset empties the table by clearing the fill count only.
module arp_cache_transpose_core #(
  parameter int unsigned TableDepth = arpct_pkg::TABLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  arpct_req_if.sink    req_i,
  arpct_rsp_if.source  rsp_o,
  arpct_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW = $clog2(TableDepth);

  logic [arpct_pkg::IP_W-1:0] my_ip_q, my_ip_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  arpct_pkg::entry_t ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  arpct_pkg::entry_t ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    my_ip_d = my_ip_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        arpct_pkg::CFG_MY_IP: my_ip_d = cfg_i.data[arpct_pkg::IP_W-1:0];
        // own mac only goes into frames built outside this block
        arpct_pkg::CFG_MY_MAC: my_ip_d = my_ip_q;
        default: my_ip_d = my_ip_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q <= '0;
    end else begin
      my_ip_q <= my_ip_d;
    end
  end

  arpct_ram #(
    .Width ($bits(arpct_pkg::entry_t)),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  arpct_ctrl #(
    .TableDepth (TableDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .my_ip_i     (my_ip_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the arp cache with transpose lookup
`timescale 1ns / 1ps

module testbench;
  import arpct_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [IP_W-1:0]  MY_IP0     = 32'hC0A8_0001;
  localparam int unsigned      WD_LIMIT   = 1000;
  localparam int unsigned      POOL_N     = 12;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IP_W-1:0]  sip;
    logic [MAC_W-1:0] smac;
    logic [IP_W-1:0]  tip;
  } arp_req_t;

  typedef struct {
    arp_req_t item;
    bit       has_want;
    rsp_t     want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  arpct_req_if req_if ();
  arpct_rsp_if rsp_if ();
  arpct_cfg_if cfg_if ();

  arp_cache_transpose_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the cache and its registers
  logic [IP_W-1:0]  tbl_ip  [TABLE_DEPTH];
  logic [MAC_W-1:0] tbl_mac [TABLE_DEPTH];
  int unsigned      tbl_fill;
  logic [IP_W-1:0]  cfg_ip;
  logic [MAC_W-1:0] cfg_mac;

  rsp_t             want_rsp_q [$];
  dir_row_t         dir_tab [$];
  logic [IP_W-1:0]  ip_pool  [POOL_N];
  logic [MAC_W-1:0] mac_pool [POOL_N];
  int unsigned      err_cnt;
  bit               idle_on;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic rsp_t next_arp_rsp(arp_req_t it);
    rsp_t             r;
    bit               done;
    logic [MAC_W-1:0] hit_mac;
    int unsigned      k;
    r = '0;
    done = 1'b0;
    case (it.cmd)
      CMD_LEARN: begin
        for (k = 0; k < tbl_fill; k++) begin
          if (!done && tbl_mac[k] == it.smac) begin
            tbl_ip[k] = it.sip;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (tbl_fill < TABLE_DEPTH) begin
            tbl_ip[tbl_fill]  = it.sip;
            tbl_mac[tbl_fill] = it.smac;
            tbl_fill++;
          end else begin
            // full table: the last slot is replaced
            tbl_ip[TABLE_DEPTH-1]  = it.sip;
            tbl_mac[TABLE_DEPTH-1] = it.smac;
          end
        end
      end
      CMD_REQUEST: begin
        if (it.tip == cfg_ip) begin
          r.send_reply = 1'b1;
          r.peer_ip    = it.sip;
          r.peer_mac   = it.smac;
        end
      end
      CMD_RESOLVE: begin
        for (k = 0; k < tbl_fill; k++) begin
          if (!done && tbl_ip[k] == it.tip) begin
            done        = 1'b1;
            hit_mac     = tbl_mac[k];
            r.found     = 1'b1;
            r.found_mac = hit_mac;
            // move the hit one slot toward the front
            if (k > 0) begin
              tbl_ip[k]    = tbl_ip[k-1];
              tbl_mac[k]   = tbl_mac[k-1];
              tbl_ip[k-1]  = it.tip;
              tbl_mac[k-1] = hit_mac;
            end
          end
        end
        if (!done) begin
          r.send_request = 1'b1;
          r.peer_ip      = it.tip;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 4) != 0) return ip_pool[$urandom_range(0, POOL_N-1)];
    return $urandom;
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(0, 4) != 0) return mac_pool[$urandom_range(0, POOL_N-1)];
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic arp_req_t rand_item();
    arp_req_t    it;
    int unsigned pick;
    it.sip  = pick_ip();
    it.smac = pick_mac();
    it.tip  = pick_ip();
    pick    = $urandom_range(0, 99);
    if (pick < 30) begin
      it.cmd = CMD_LEARN;
    end else if (pick < 55) begin
      it.cmd = CMD_REQUEST;
      if ($urandom_range(0, 4) < 3) it.tip = cfg_ip;
    end else if (pick < 96) begin
      it.cmd = CMD_RESOLVE;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  function automatic void add_row(arp_req_t it, bit has_want, rsp_t want);
    dir_row_t row;
    row.item     = it;
    row.has_want = has_want;
    row.want     = want;
    dir_tab.push_back(row);
  endfunction

  // leaves valid high at the accepting edge
  task automatic send_item(arp_req_t it, bit has_want, rsp_t want);
    rsp_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.cmd     <= it.cmd;
    req_if.src_ip  <= it.sip;
    req_if.src_mac <= it.smac;
    req_if.tgt_ip  <= it.tip;
    do @(posedge clk_i); while (!req_if.ready);
    pred = next_arp_rsp(it);
    want_rsp_q.push_back(has_want ? want : pred);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (want_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_MY_IP) cfg_ip = val[IP_W-1:0];
    else cfg_mac = val[MAC_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    arp_req_t    it;
    int unsigned done_n;
    done_n = 0;
    while (done_n < n) begin
      it = rand_item();
      send_item(it, 1'b0, '0);
      if (it.cmd != CMD_UNUSED) done_n++;
    end
  endtask

  // response checking against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.found        = rsp_if.found;
      got.found_mac    = rsp_if.found_mac;
      got.send_request = rsp_if.send_request;
      got.send_reply   = rsp_if.send_reply;
      got.peer_ip      = rsp_if.peer_ip;
      got.peer_mac     = rsp_if.peer_mac;
      if (want_rsp_q.size() == 0) begin
        $error("unexpected response %h", got);
        err_cnt++;
      end else begin
        want = want_rsp_q.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %h, got %h", want.found, got.found);
          err_cnt++;
        end
        if (got.found_mac !== want.found_mac) begin
          $error("found_mac: expected %h, got %h", want.found_mac, got.found_mac);
          err_cnt++;
        end
        if (got.send_request !== want.send_request) begin
          $error("send_request: expected %h, got %h", want.send_request, got.send_request);
          err_cnt++;
        end
        if (got.send_reply !== want.send_reply) begin
          $error("send_reply: expected %h, got %h", want.send_reply, got.send_reply);
          err_cnt++;
        end
        if (got.peer_ip !== want.peer_ip) begin
          $error("peer_ip: expected %h, got %h", want.peer_ip, got.peer_ip);
          err_cnt++;
        end
        if (got.peer_mac !== want.peer_mac) begin
          $error("peer_mac: expected %h, got %h", want.peer_mac, got.peer_mac);
          err_cnt++;
        end
      end
    end
  end

  // response sink stalls in short bursts while idle_on is set
  initial begin
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ends the run when no handshake happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.cmd     <= CMD_LEARN;
    req_if.src_ip  <= '0;
    req_if.src_mac <= '0;
    req_if.tgt_ip  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_MY_IP;
    cfg_if.data    <= '0;
    err_cnt  = 0;
    idle_on  = 1'b1;
    tbl_fill = 0;
    cfg_ip   = '0;
    cfg_mac  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_ip[i]  = '0;
      tbl_mac[i] = '0;
    end
    for (int i = 0; i < POOL_N; i++) begin
      ip_pool[i]  = $urandom;
      mac_pool[i] = {16'($urandom), 32'($urandom)};
    end
    ip_pool[0]  = '0;
    ip_pool[1]  = '1;
    mac_pool[0] = '0;
    mac_pool[1] = '1;

    // directed rows: cmd, sender ip, sender mac, target ip
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'hFFFF_FFFF}, 1'b1,
            rsp_t'{1'b0, 48'h0, 1'b1, 1'b0, 32'hFFFF_FFFF, 48'h0});
    add_row('{CMD_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, MY_IP0}, 1'b1,
            rsp_t'{1'b0, 48'h0, 1'b0, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF});
    add_row('{CMD_REQUEST, 32'h0, 48'h0, MY_IP0}, 1'b1,
            rsp_t'{1'b0, 48'h0, 1'b0, 1'b1, 32'h0, 48'h0});
    add_row('{CMD_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, ~MY_IP0}, 1'b1, '0);
    add_row('{CMD_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0A00_0001, 48'h0200_0000_0001, 32'h0}, 1'b1, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0A00_0001}, 1'b0, '0);
    add_row('{CMD_LEARN, 32'h0A00_0002, 48'h0200_0000_0002, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0, 48'h0, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0A00_0005, 48'h0200_0000_0005, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0A00_0006, 48'h0200_0000_0006, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0A00_0007, 48'h0200_0000_0007, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0A00_0008, 48'h0200_0000_0008, 32'h0}, 1'b1, '0);
    // table is full from here on
    add_row('{CMD_LEARN, 32'h0B00_0009, 48'h0200_0000_0009, 32'h0}, 1'b1, '0);
    add_row('{CMD_LEARN, 32'h0C00_0004, 48'h0, 32'h0}, 1'b1, '0);
    // second entry with an ip already held lower in the table
    add_row('{CMD_LEARN, 32'h0A00_0002, 48'h0200_0000_000A, 32'h0}, 1'b1, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0A00_0002}, 1'b0, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'hFFFF_FFFF}, 1'b0, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0C00_0004}, 1'b0, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0B00_0009}, 1'b1,
            rsp_t'{1'b0, 48'h0, 1'b1, 1'b0, 32'h0B00_0009, 48'h0});
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0A00_0002}, 1'b0, '0);
    add_row('{CMD_RESOLVE, 32'h0, 48'h0, 32'h0}, 1'b1,
            rsp_t'{1'b0, 48'h0, 1'b1, 1'b0, 32'h0, 48'h0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_MY_IP, {16'hFFFF, MY_IP0});
    write_reg(CFG_MY_MAC, 48'hFFFF_FFFF_FFFF);
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_want, dir_tab[i].want);
    wait_drained();

    write_reg(CFG_MY_IP, 48'h0);
    write_reg(CFG_MY_MAC, 48'h0);
    run_random(400);
    wait_drained();

    write_reg(CFG_MY_IP, {16'($urandom), 32'hFFFF_FFFF});
    write_reg(CFG_MY_MAC, {16'($urandom), 32'($urandom)});
    run_random(400);
    wait_drained();

    write_reg(CFG_MY_IP, {16'($urandom), 32'($urandom)});
    run_random(200);
    // sender holds off until the cache has answered everything
    wait_drained();
    run_random(200);
    wait_drained();

    write_reg(CFG_MY_IP, {16'($urandom), ip_pool[$urandom_range(0, POOL_N-1)]});
    write_reg(CFG_MY_MAC, {16'($urandom), 32'($urandom)});
    idle_on = 1'b0;
    run_random(700);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && want_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
